[hw/rtl/fptt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fptt_pkg
// Shared types, register indexes and fixed-point helpers of the optimizer
// update core.
// ----------------------------------------------------------------------------
package fptt_pkg;

   // Q8.24 data word and the fraction width of every product
   localparam int WORD_W   = 32;
   localparam int FRAC_W   = 24;
   localparam int COEF_W   = 31;
   localparam int PROD_W   = 2 * WORD_W;
   localparam int WIDE_W   = PROD_W - FRAC_W;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;
   localparam int LR_W        = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_FPTT_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEARN_RATE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_GAIN     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_INV_ALPHA = 2'd3;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic        [COEF_W-1:0] coef_type;

   // saturated value with its clip flag
   typedef struct packed {
      logic     flag;
      word_type value;
   } sat_type;

   // payload that travels down the update pipeline
   typedef struct packed {
      word_type weight;
      word_type grad;
      word_type mean;
      word_type mult;
      word_type new_weight;
      word_type work;
      logic     sat;
      logic     last;
   } element_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // sign-extend a data word to the wide working range
   function automatic wide_type widen(input word_type x);
      widen = {{(WIDE_W-WORD_W){x[WORD_W-1]}}, x};
   endfunction

   // floor shift of a product by the fraction width
   function automatic wide_type prod_shift(input prod_type p);
      prod_shift = p[PROD_W-1:FRAC_W];
   endfunction

   // clip a wide value to the signed word range
   function automatic sat_type sat_word(input wide_type x);
      sat_type r;
      if (x > widen(WORD_MAX)) begin
         r.flag  = 1'b1;
         r.value = WORD_MAX;
      end else if (x < widen(WORD_MIN)) begin
         r.flag  = 1'b1;
         r.value = WORD_MIN;
      end else begin
         r.flag  = 1'b0;
         r.value = x[WORD_W-1:0];
      end
      sat_word = r;
   endfunction

endpackage : fptt_pkg
`default_nettype wire

[hw/rtl/fptt_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fptt_req_if
// Element channel into the update core: valid/ready with the element fields.
// ----------------------------------------------------------------------------
interface fptt_req_if;
   logic                valid;
   logic                ready;
   fptt_pkg::word_type  weight_in;
   fptt_pkg::word_type  gradient_in;
   fptt_pkg::word_type  mean_in;
   fptt_pkg::word_type  multiplier_in;
   logic                last_element;

   modport source (
      output valid, weight_in, gradient_in, mean_in, multiplier_in, last_element,
      input  ready
   );
   modport sink (
      input  valid, weight_in, gradient_in, mean_in, multiplier_in, last_element,
      output ready
   );
endinterface : fptt_req_if
`default_nettype wire

[hw/rtl/fptt_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fptt_rsp_if
// Result channel out of the update core: valid/ready with the updated fields.
// ----------------------------------------------------------------------------
interface fptt_rsp_if;
   logic                valid;
   logic                ready;
   fptt_pkg::word_type  weight_out;
   fptt_pkg::word_type  mean_out;
   fptt_pkg::word_type  multiplier_out;
   logic                saturated;
   logic                last_out;

   modport source (
      output valid, weight_out, mean_out, multiplier_out, saturated, last_out,
      input  ready
   );
   modport sink (
      input  valid, weight_out, mean_out, multiplier_out, saturated, last_out,
      output ready
   );
endinterface : fptt_rsp_if
`default_nettype wire

[hw/rtl/fptt_sgd_param_update_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fptt_sgd_param_update_core
// Per-element optimizer update: plain SGD or FPTT-regularised SGD on signed
// Q8.24 weight, gradient, running mean and multiplier, with saturation flag.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  req_chan  | in        | valid / ready      | weight, gradient, mean, mult, last
//  rsp_chan  | out       | valid / ready      | weight, mean, mult, saturated, last
//  csr_*     | in        | csr_wr_en          | csr_index, csr_wdata
//
//  One element per cycle unless the result side stalls; an accepted element
//  reaches rsp valid through the FPTT dependency chain: nine pipeline stages,
//  four of them registered multiplies, then the result register.
//  Synchronous active-high reset clears the valid bits and the configuration
//  registers; payload registers are left as they are.
//  The whole pipeline advances when the result register is empty or taken;
//  otherwise every stage holds, and req_chan.ready drops.
//  The user must write registers only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module fptt_sgd_param_update_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fptt_req_if.sink                               req_chan,
   fptt_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [fptt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [fptt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fptt_pkg::*;

   localparam int NUM_STAGES = 9;

   // configuration registers
   logic            fptt_enable_ff;
   logic [LR_W-1:0] learn_rate_ff;
   coef_type        alpha_gain_ff;
   coef_type        half_inv_alpha_ff;

   // pipeline registers
   element_type               pipe_ff [1:NUM_STAGES];
   element_type               pipe_in [1:NUM_STAGES];
   logic [NUM_STAGES:1]       pipe_valid_ff;
   logic [NUM_STAGES:1]       pipe_valid_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   word_type                  rsp_weight_ff;
   word_type                  rsp_mean_ff;
   word_type                  rsp_mult_ff;
   logic                      rsp_sat_ff;
   logic                      rsp_last_ff;
   word_type                  rsp_mean_in;
   logic                      rsp_sat_in;

   logic     advance;
   prod_type ad_prod;
   prod_type step_prod;
   prod_type ad2_prod;
   prod_type hl_prod;
   coef_type lr_coef;

   sat_type  d_sat;
   sat_type  ad_sat;
   sat_type  e_sat;
   sat_type  wn_sat;
   sat_type  d2_sat;
   sat_type  ad2_sat;
   sat_type  ln_sat;
   sat_type  mn_sat;

   // hold everything while a finished result waits
   assign advance       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // register writes; indexes cover the whole list
   always_ff @(posedge clock) begin
      if (reset) begin
         fptt_enable_ff    <= 1'b0;
         learn_rate_ff     <= '0;
         alpha_gain_ff     <= '0;
         half_inv_alpha_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FPTT_ENABLE:    fptt_enable_ff    <= csr_wdata[0];
            CSR_LEARN_RATE:     learn_rate_ff     <= csr_wdata[LR_W-1:0];
            CSR_ALPHA_GAIN:     alpha_gain_ff     <= csr_wdata[COEF_W-1:0];
            CSR_HALF_INV_ALPHA: half_inv_alpha_ff <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   assign lr_coef = {{(COEF_W-LR_W){1'b0}}, learn_rate_ff};

   // multipliers: a*d, lr*e, a*d2, h*l'
   fptt_mult u_mult_ad (
      .clock      (clock),
      .advance    (advance),
      .coef       (alpha_gain_ff),
      .operand    (pipe_ff[1].work),
      .product_ff (ad_prod)
   );

   fptt_mult u_mult_step (
      .clock      (clock),
      .advance    (advance),
      .coef       (lr_coef),
      .operand    (pipe_ff[3].work),
      .product_ff (step_prod)
   );

   fptt_mult u_mult_ad2 (
      .clock      (clock),
      .advance    (advance),
      .coef       (alpha_gain_ff),
      .operand    (pipe_ff[6].work),
      .product_ff (ad2_prod)
   );

   fptt_mult u_mult_hl (
      .clock      (clock),
      .advance    (advance),
      .coef       (half_inv_alpha_ff),
      .operand    (pipe_ff[8].mult),
      .product_ff (hl_prod)
   );

   // saturating arithmetic of each stage
   assign d_sat   = sat_word(widen(req_chan.weight_in) - widen(req_chan.mean_in));
   assign ad_sat  = sat_word(prod_shift(ad_prod));
   assign e_sat   = sat_word(widen(pipe_ff[2].grad) - widen(pipe_ff[2].mult)
                             + widen(ad_sat.value));
   assign wn_sat  = sat_word(widen(pipe_ff[4].weight) - prod_shift(step_prod));
   assign d2_sat  = sat_word(widen(pipe_ff[5].new_weight) - widen(pipe_ff[5].mean));
   assign ad2_sat = sat_word(prod_shift(ad2_prod));
   assign ln_sat  = sat_word(widen(pipe_ff[7].mult) - widen(ad2_sat.value));

   // floor half of (m + w') then subtract the multiplier term
   logic signed [WORD_W:0] mw_sum;
   assign mw_sum = {pipe_ff[9].mean[WORD_W-1], pipe_ff[9].mean}
                 + {pipe_ff[9].new_weight[WORD_W-1], pipe_ff[9].new_weight};
   assign mn_sat = sat_word(widen(mw_sum[WORD_W:1]) - prod_shift(hl_prod));

   // next value of each stage
   always_comb begin
      // take the element and form d = w - m
      pipe_in[1].weight     = req_chan.weight_in;
      pipe_in[1].grad       = req_chan.gradient_in;
      pipe_in[1].mean       = req_chan.mean_in;
      pipe_in[1].mult       = req_chan.multiplier_in;
      pipe_in[1].new_weight = req_chan.weight_in;
      pipe_in[1].work       = d_sat.value;
      pipe_in[1].sat        = fptt_enable_ff && d_sat.flag;
      pipe_in[1].last       = req_chan.last_element;

      // a*d in flight
      pipe_in[2] = pipe_ff[1];

      // step direction e = g - l + a*d, or the plain gradient
      pipe_in[3] = pipe_ff[2];
      if (fptt_enable_ff) begin
         pipe_in[3].work = e_sat.value;
         pipe_in[3].sat  = pipe_ff[2].sat || ad_sat.flag || e_sat.flag;
      end else begin
         pipe_in[3].work = pipe_ff[2].grad;
      end

      // lr*e in flight
      pipe_in[4] = pipe_ff[3];

      // new weight
      pipe_in[5]            = pipe_ff[4];
      pipe_in[5].new_weight = wn_sat.value;
      pipe_in[5].sat        = pipe_ff[4].sat || wn_sat.flag;

      // d2 = w' - m
      pipe_in[6]      = pipe_ff[5];
      pipe_in[6].work = d2_sat.value;
      pipe_in[6].sat  = pipe_ff[5].sat || (fptt_enable_ff && d2_sat.flag);

      // a*d2 in flight
      pipe_in[7] = pipe_ff[6];

      // new multiplier
      pipe_in[8] = pipe_ff[7];
      if (fptt_enable_ff) begin
         pipe_in[8].mult = ln_sat.value;
         pipe_in[8].sat  = pipe_ff[7].sat || ad2_sat.flag || ln_sat.flag;
      end

      // h*l' in flight
      pipe_in[9] = pipe_ff[8];

      // new mean
      if (fptt_enable_ff) begin
         rsp_mean_in = mn_sat.value;
         rsp_sat_in  = pipe_ff[9].sat || mn_sat.flag;
      end else begin
         rsp_mean_in = pipe_ff[9].mean;
         rsp_sat_in  = pipe_ff[9].sat;
      end
   end

   // valid bits shift with the data
   assign pipe_valid_in = {pipe_valid_ff[NUM_STAGES-1:1], req_chan.valid};
   assign rsp_valid_in  = pipe_valid_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload advances with the pipeline, holds on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff       <= pipe_in;
         rsp_weight_ff <= pipe_ff[9].new_weight;
         rsp_mean_ff   <= rsp_mean_in;
         rsp_mult_ff   <= pipe_ff[9].mult;
         rsp_sat_ff    <= rsp_sat_in;
         rsp_last_ff   <= pipe_ff[9].last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.weight_out     = rsp_weight_ff;
   assign rsp_chan.mean_out       = rsp_mean_ff;
   assign rsp_chan.multiplier_out = rsp_mult_ff;
   assign rsp_chan.saturated      = rsp_sat_ff;
   assign rsp_chan.last_out       = rsp_last_ff;

   // an accepted transaction lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> pipe_valid_ff[1])
      else $error("accepted transaction not captured in first stage");

   // back-pressure only from a held result
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_valid_ff && !rsp_chan.ready))
      else $error("input stalled without a blocked result");

   // a stalled pipeline keeps its occupancy
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pipe_valid_ff) && rsp_valid_ff)
      else $error("pipeline occupancy changed during stall");

endmodule : fptt_sgd_param_update_core
`default_nettype wire

[hw/rtl/fptt_mult.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fptt_mult
// Registered multiply of an unsigned coefficient by a signed Q8.24 word,
// held while the pipeline is stalled.
// ----------------------------------------------------------------------------
module fptt_mult (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire fptt_pkg::coef_type  coef,
   input  wire fptt_pkg::word_type  operand,
   output fptt_pkg::prod_type       product_ff
);
   import fptt_pkg::*;

   prod_type product_in;

   // zero-extend the coefficient so that the product is signed
   assign product_in = $signed({1'b0, coef}) * operand;

   // capture on advance, hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff <= product_in;
      end
   end

endmodule : fptt_mult
`default_nettype wire

[tb/sv/fptt_update_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fptt_update_checker
// Passive checker for the optimizer update core. It mirrors the register
// writes and works out the updated weight, mean and multiplier of every
// accepted element. Each returned update is compared with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module fptt_update_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fptt_req_if                                    req_mon,
   fptt_rsp_if                                    rsp_mon,
   input  wire logic                              csr_wr_en,
   input  wire logic [fptt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [fptt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                     fail_count,
   output int                                     outstanding
);
   import fptt_pkg::*;

   localparam longint WORD_HI      = 64'sd2147483647;
   localparam longint WORD_LO      = -64'sd2147483648;
   localparam int     REPORT_LIMIT = 100;

   typedef struct packed {
      word_type weight;
      word_type mean;
      word_type mult;
      logic     sat;
      logic     last;
   } update_type;

   // mirrored register file
   logic            fptt_mode;
   logic [LR_W-1:0] lr_reg;
   coef_type        alpha_reg;
   coef_type        half_inv_reg;

   update_type      predicted_updates[$];
   int              fails;

   // clip to the signed word range and note any clipping
   function automatic longint clip_word(input longint x, inout logic clipped);
      if (x > WORD_HI) begin
         clipped = 1'b1;
         return WORD_HI;
      end
      if (x < WORD_LO) begin
         clipped = 1'b1;
         return WORD_LO;
      end
      return x;
   endfunction

   // updated element under the mirrored registers; >>> on signed is a floor
   function automatic update_type predict_update(input word_type w_in,
                                                 input word_type g_in,
                                                 input word_type m_in,
                                                 input word_type l_in,
                                                 input logic     last_in);
      longint     w, g, m, l, lr, a, h;
      longint     d, ad, e, d2, ad2, wn, mn, ln;
      logic       clipped;
      update_type r;
      clipped = 1'b0;
      w  = w_in;
      g  = g_in;
      m  = m_in;
      l  = l_in;
      lr = lr_reg;
      a  = alpha_reg;
      h  = half_inv_reg;
      if (fptt_mode) begin
         d   = clip_word(w - m, clipped);
         ad  = clip_word((a * d) >>> FRAC_W, clipped);
         e   = clip_word(g - l + ad, clipped);
         wn  = clip_word(w - ((lr * e) >>> FRAC_W), clipped);
         d2  = clip_word(wn - m, clipped);
         ad2 = clip_word((a * d2) >>> FRAC_W, clipped);
         ln  = clip_word(l - ad2, clipped);
         mn  = clip_word(((m + wn) >>> 1) - ((h * ln) >>> FRAC_W), clipped);
      end else begin
         wn = clip_word(w - ((lr * g) >>> FRAC_W), clipped);
         mn = m;
         ln = l;
      end
      r.weight = wn[WORD_W-1:0];
      r.mean   = mn[WORD_W-1:0];
      r.mult   = ln[WORD_W-1:0];
      r.sat    = clipped;
      r.last   = last_in;
      return r;
   endfunction

   always @(posedge clock) begin
      update_type want;
      update_type got;
      if (reset) begin
         predicted_updates.delete();
         fptt_mode    = 1'b0;
         lr_reg       = '0;
         alpha_reg    = '0;
         half_inv_reg = '0;
      end else begin
         // check a returned transaction against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.weight_out, rsp_mon.mean_out, rsp_mon.multiplier_out,
                    rsp_mon.saturated, rsp_mon.last_out};
            if (predicted_updates.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display("%0t ns: update with none expected, got w=%h m=%h l=%h sat=%b last=%b",
                           $time, got.weight, got.mean, got.mult, got.sat, got.last);
            end else begin
               want = predicted_updates.pop_front();
               if (got !== want) begin
                  fails++;
                  if (fails <= REPORT_LIMIT)
                     $display({"%0t ns: update mismatch, expected w=%h m=%h l=%h sat=%b last=%b,",
                               " got w=%h m=%h l=%h sat=%b last=%b"},
                              $time, want.weight, want.mean, want.mult, want.sat, want.last,
                              got.weight, got.mean, got.mult, got.sat, got.last);
               end
            end
         end

         // predict an accepted element under the registers in force now
         if (req_mon.valid && req_mon.ready)
            predicted_updates.push_back(predict_update(req_mon.weight_in,
                                                       req_mon.gradient_in,
                                                       req_mon.mean_in,
                                                       req_mon.multiplier_in,
                                                       req_mon.last_element));

         // mirror register writes, masked to each register's width
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FPTT_ENABLE:    fptt_mode    = csr_wdata[0];
               CSR_LEARN_RATE:     lr_reg       = csr_wdata[LR_W-1:0];
               CSR_ALPHA_GAIN:     alpha_reg    = csr_wdata[COEF_W-1:0];
               CSR_HALF_INV_ALPHA: half_inv_reg = csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count  <= fails;
      outstanding <= predicted_updates.size();
   end

endmodule : fptt_update_checker

[tb/sv/fptt_sgd_param_update_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fptt_sgd_param_update_core_tb
// Drives the optimizer update core with directed corner elements and then
// random streams under a series of register settings, SGD and FPTT, with
// bursty input and a stalling result side. The checker beside the core
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module fptt_sgd_param_update_core_tb;
   import fptt_pkg::*;

   localparam int RESET_CYCLES    = 11;
   localparam int HOLD_CYCLES     = 160;
   localparam int DRAIN_CYCLES    = 24;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int RUN_LIMIT_NS    = 500_000;

   localparam logic [CSR_DATA_W-1:0] DATA_ALL = '1;
   localparam logic [CSR_DATA_W-1:0] ONE_Q24  = 31'h0100_0000;
   localparam logic [CSR_DATA_W-1:0] HALF_Q24 = 31'h0080_0000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     outstanding;
   bit                     hold_request;
   int                     burst_left;

   fptt_req_if req_link ();
   fptt_rsp_if rsp_link ();

   fptt_sgd_param_update_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_link),
      .rsp_chan  (rsp_link),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fptt_update_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_link),
      .rsp_mon     (rsp_link),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // abandon a hung run
   initial begin
      #(RUN_LIMIT_NS);
      $display("fptt_sgd_param_update_core verification failed");
      $finish;
   end

   // result side: stall rate steps through 0, 25, 50, 0 and 85 percent, long hold on request
   initial begin : result_sink
      int rx_cycle;
      int stall_pct;
      rx_cycle = 0;
      rsp_link.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_link.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            case ((rx_cycle / 131) % 5)
               0, 3:    stall_pct = 0;
               1:       stall_pct = 25;
               2:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
            rsp_link.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
         rx_cycle++;
      end
   end

   // random word: mostly near zero, some full range, some at the extremes
   function automatic word_type rand_word();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2, 3:    return word_type'($urandom());
         default: return word_type'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   // offer one element; open a new burst after a random gap when one runs out
   task automatic send_element(input word_type w, input word_type g, input word_type m,
                               input word_type l, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_link.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_link.valid         <= 1'b1;
      req_link.weight_in     <= w;
      req_link.gradient_in   <= g;
      req_link.mean_in       <= m;
      req_link.multiplier_in <= l;
      req_link.last_element  <= last;
      do @(posedge clock); while (!(req_link.valid && req_link.ready));
      burst_left--;
   endtask

   // drop valid and hold until every predicted update has come back
   task automatic wait_drained();
      req_link.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // write all four registers back to back while the core is empty
   task automatic load_registers(input logic [CSR_DATA_W-1:0] enable_word,
                                 input logic [CSR_DATA_W-1:0] lr_word,
                                 input logic [CSR_DATA_W-1:0] alpha_word,
                                 input logic [CSR_DATA_W-1:0] half_inv_word);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FPTT_ENABLE;
      csr_wdata <= enable_word;
      @(posedge clock);
      csr_index <= CSR_LEARN_RATE;
      csr_wdata <= lr_word;
      @(posedge clock);
      csr_index <= CSR_ALPHA_GAIN;
      csr_wdata <= alpha_word;
      @(posedge clock);
      csr_index <= CSR_HALF_INV_ALPHA;
      csr_wdata <= half_inv_word;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] en_w, lr_w, al_w, hi_w;
      hold_request = 1'b0;
      burst_left   = 0;
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_index              <= CSR_FPTT_ENABLE;
      csr_wdata              <= '0;
      req_link.valid         <= 1'b0;
      req_link.weight_in     <= '0;
      req_link.gradient_in   <= '0;
      req_link.mean_in       <= '0;
      req_link.multiplier_in <= '0;
      req_link.last_element  <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // registers as left by reset: SGD with zero rate
      send_element(WORD_MAX, WORD_MIN, 32'sd0, 32'sd0, 1'b1);
      send_element(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b0);
      wait_drained();

      // SGD at full rate; enable and rate words carry bits beyond their width,
      // and the FPTT coefficients are set but must have no effect
      load_registers(DATA_ALL & ~31'd1, DATA_ALL, DATA_ALL, DATA_ALL);
      send_element(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 1'b0);
      send_element(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b1);
      send_element(32'sd0, 32'sh0100_0000, 32'sd5, -32'sd5, 1'b0);
      send_element(32'sd0, -32'sd1, 32'sd0, 32'sd0, 1'b0);
      send_element(WORD_MAX, -32'sd1, 32'sd0, 32'sd0, 1'b1);
      wait_drained();

      // FPTT with consistent coefficients: alpha 1.0, half-inverse 0.5
      load_registers(31'd1, HALF_Q24, ONE_Q24, HALF_Q24);
      send_element(32'sh0100_0000, 32'sh0040_0000, 32'sh0080_0000, -32'sh0080_0000, 1'b1);
      send_element(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0);
      send_element(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 1'b0);
      send_element(WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, 1'b1);
      send_element(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
      wait_drained();

      // FPTT with the largest alpha and a zero half-inverse: multiplier term drops
      load_registers(31'd1, 31'h00FF_FFFF, DATA_ALL, '0);
      send_element(32'sh0000_1000, -32'sh0000_2000, 32'sh0000_0800, 32'sh0000_0100, 1'b0);
      send_element(32'sh0200_0000, 32'sh0010_0000, 32'sh01F0_0000, -32'sh0001_0000, 1'b1);
      send_element(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 1'b0);
      send_element(-32'sd3, 32'sd7, 32'sd2, -32'sd9, 1'b1);
      wait_drained();

      // FPTT at zero rate and zero alpha, half-inverse out of step with alpha
      load_registers(DATA_ALL, '0, '0, DATA_ALL);
      send_element(32'sh0100_0000, 32'sh0300_0000, -32'sh0100_0000, 32'sh0000_0003, 1'b0);
      send_element(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, 1'b1);
      send_element(WORD_MIN, 32'sd0, WORD_MIN, WORD_MAX, 1'b0);
      wait_drained();

      // random streams, one register setting per phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         lr_w = CSR_DATA_W'($urandom_range(0, 24'h20_0000));
         al_w = CSR_DATA_W'($urandom_range(0, 32'h0400_0000));
         hi_w = CSR_DATA_W'($urandom_range(0, 32'h0400_0000));
         en_w = 31'd1;
         case (phase)
            0: begin
               en_w = CSR_DATA_W'($urandom()) & ~31'd1;
               lr_w = CSR_DATA_W'($urandom());
               al_w = CSR_DATA_W'($urandom());
               hi_w = CSR_DATA_W'($urandom());
            end
            2: begin
               en_w = CSR_DATA_W'($urandom()) | 31'd1;
               lr_w = CSR_DATA_W'($urandom());
               al_w = CSR_DATA_W'($urandom());
               hi_w = CSR_DATA_W'($urandom());
            end
            3: begin
               en_w = '0;
               lr_w = DATA_ALL;
            end
            4: begin
               lr_w = DATA_ALL;
               al_w = DATA_ALL;
               hi_w = DATA_ALL;
            end
            6: begin
               en_w = '0;
               lr_w = '0;
               al_w = CSR_DATA_W'($urandom());
            end
            7: hi_w = '0;
            default: ;
         endcase
         load_registers(en_w, lr_w, al_w, hi_w);
         // fill the core behind a long result stall in one SGD and one FPTT phase
         if (phase == 1 || phase == 3)
            hold_request = 1'b1;
         repeat (ITEMS_PER_PHASE)
            send_element(rand_word(), rand_word(), rand_word(), rand_word(),
                         $urandom_range(0, 7) == 0);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("fptt_sgd_param_update_core verification clean");
      else
         $display("fptt_sgd_param_update_core verification failed");
      $finish;
   end

endmodule : fptt_sgd_param_update_core_tb
